// ----- design/ias_pkg.sv -----
// Package for the IAS execute unit: opcodes and controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps
package ias_pkg;

  localparam logic [7:0] OP_LOAD      = 8'h01;
  localparam logic [7:0] OP_LOAD_NEG  = 8'h02;
  localparam logic [7:0] OP_LOAD_ABS  = 8'h03;
  localparam logic [7:0] OP_LOAD_NABS = 8'h04;
  localparam logic [7:0] OP_ADD       = 8'h05;
  localparam logic [7:0] OP_SUB       = 8'h06;
  localparam logic [7:0] OP_ADD_ABS   = 8'h07;
  localparam logic [7:0] OP_SUB_ABS   = 8'h08;
  localparam logic [7:0] OP_LOAD_MQ   = 8'h09;
  localparam logic [7:0] OP_MQ_TO_AC  = 8'h0A;
  localparam logic [7:0] OP_MUL       = 8'h0B;
  localparam logic [7:0] OP_DIV       = 8'h0C;
  localparam logic [7:0] OP_JMP_L     = 8'h0D;
  localparam logic [7:0] OP_JMP_R     = 8'h0E;
  localparam logic [7:0] OP_JPOS_L    = 8'h0F;
  localparam logic [7:0] OP_JPOS_R    = 8'h10;
  localparam logic [7:0] OP_STOR_L    = 8'h12;
  localparam logic [7:0] OP_STOR_R    = 8'h13;
  localparam logic [7:0] OP_LSH       = 8'h14;
  localparam logic [7:0] OP_RSH       = 8'h15;
  localparam logic [7:0] OP_STOR      = 8'h21;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch the transaction, run the non-iterative ops
    logic mul_init; // start a multiply
    logic div_init; // start a divide
    logic step;     // one iteration of multiply or divide
    logic mul_done; // write multiply result
    logic div_done; // write divide result
  } ias_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
  } ias_sts_t;

endpackage

// ----- design/ias_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface ias_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/ias_datapath.sv -----
// Datapath of the IAS execute unit: AC, MQ, halt flag, iterative mul/div.
// Depends on ias_pkg.
`timescale 1ns / 1ps
module ias_datapath #(
  parameter int WORD_BITS = 40,
  parameter int ADDR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ias_pkg::ias_cmd_t    cmd,
  output ias_pkg::ias_sts_t    sts,
  input  logic                 in_end_marker,
  input  logic [7:0]           in_opcode,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [WORD_BITS-1:0] in_operand,
  output logic                 r_store_valid,
  output logic [ADDR_BITS-1:0] r_store_addr,
  output logic [WORD_BITS-1:0] r_store_data,
  output logic                 r_jump_taken,
  output logic [ADDR_BITS-1:0] r_jump_target,
  output logic                 r_jump_right_half,
  output logic                 r_refetch,
  output logic                 r_halted,
  output logic                 r_divide_fault,
  output logic [WORD_BITS-1:0] r_acc
);
  localparam int HB = WORD_BITS / 2;

  logic [WORD_BITS-1:0] ac_r, mq_r, ac_nxt, mq_nxt;
  logic                 halt_r, halt_nxt;
  logic [WORD_BITS-1:0] a_r, b_r, p_r, rem_r, q_r;
  logic                 qneg_r, rneg_r;
  logic [WORD_BITS-1:0] m, m_abs, ac_abs, fld;
  logic [WORD_BITS:0]   trial;
  logic                 sv_r, jt_r, jr_r, rf_r, df_r;
  logic [ADDR_BITS-1:0] sa_r, jtg_r;
  logic [WORD_BITS-1:0] sd_r;
  logic                 mul_r, div_r;

  assign m      = in_operand;
  assign m_abs  = m[WORD_BITS-1] ? -m : m;
  assign ac_abs = ac_r[WORD_BITS-1] ? -ac_r : ac_r;
  assign fld    = {{(WORD_BITS-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}} << HB;
  assign trial  = {rem_r, q_r[WORD_BITS-1]} - {1'b0, b_r};

  // Combinational next AC/MQ for the transaction on the inputs
  always_comb begin
    ac_nxt   = ac_r;
    mq_nxt   = mq_r;
    halt_nxt = halt_r;
    if (!halt_r) begin
      if (in_end_marker) halt_nxt = 1'b1;
      else begin
        case (in_opcode)
          ias_pkg::OP_LOAD:      ac_nxt = m;
          ias_pkg::OP_LOAD_NEG:  ac_nxt = -m;
          ias_pkg::OP_LOAD_ABS:  ac_nxt = m_abs;
          ias_pkg::OP_LOAD_NABS: ac_nxt = -m_abs;
          ias_pkg::OP_ADD:       ac_nxt = ac_r + m;
          ias_pkg::OP_SUB:       ac_nxt = ac_r - m;
          ias_pkg::OP_ADD_ABS:   ac_nxt = ac_r + m_abs;
          ias_pkg::OP_SUB_ABS:   ac_nxt = ac_r - m_abs;
          ias_pkg::OP_LOAD_MQ:   mq_nxt = m;
          ias_pkg::OP_MQ_TO_AC:  ac_nxt = mq_r;
          ias_pkg::OP_LSH:       ac_nxt = {ac_r[WORD_BITS-2:0], 1'b0};
          ias_pkg::OP_RSH:       ac_nxt = {ac_r[WORD_BITS-1], ac_r[WORD_BITS-1:1]};
          default: ;
        endcase
      end
    end
  end

  assign sts.is_mul = !halt_r && !in_end_marker && in_opcode == ias_pkg::OP_MUL;
  assign sts.is_div = !halt_r && !in_end_marker && in_opcode == ias_pkg::OP_DIV
                      && m != '0;

  // Hold architectural state and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_r   <= '0;
      mq_r   <= '0;
      halt_r <= 1'b0;
      mul_r  <= 1'b0;
      div_r  <= 1'b0;
    end else if (cmd.load) begin
      ac_r   <= ac_nxt;
      mq_r   <= mq_nxt;
      halt_r <= halt_nxt;
      sv_r <= 1'b0; sa_r <= '0; sd_r <= '0;
      jt_r <= 1'b0; jtg_r <= '0; jr_r <= 1'b0;
      rf_r <= 1'b0; df_r <= 1'b0;
      if (!halt_r && !in_end_marker) begin
        case (in_opcode)
          ias_pkg::OP_DIV: df_r <= (m == '0);
          ias_pkg::OP_JMP_L, ias_pkg::OP_JMP_R, ias_pkg::OP_JPOS_L,
          ias_pkg::OP_JPOS_R: begin
            if (in_opcode == ias_pkg::OP_JMP_L || in_opcode == ias_pkg::OP_JMP_R
                || !ac_r[WORD_BITS-1]) begin
              jt_r  <= 1'b1;
              jtg_r <= in_address;
              jr_r  <= (in_opcode == ias_pkg::OP_JMP_R
                        || in_opcode == ias_pkg::OP_JPOS_R);
            end
          end
          ias_pkg::OP_STOR_L: begin
            sv_r <= 1'b1; sa_r <= in_address; rf_r <= 1'b1;
            sd_r <= (m & ~fld)
                    | ({{(WORD_BITS-ADDR_BITS){1'b0}}, ac_r[ADDR_BITS-1:0]} << HB);
          end
          ias_pkg::OP_STOR_R: begin
            sv_r <= 1'b1; sa_r <= in_address; rf_r <= 1'b1;
            sd_r <= {m[WORD_BITS-1:ADDR_BITS], ac_r[ADDR_BITS-1:0]};
          end
          ias_pkg::OP_STOR: begin
            sv_r <= 1'b1; sa_r <= in_address; sd_r <= ac_r;
          end
          default: ;
        endcase
      end
    end else begin
      // Clear the store/jump/fault flags when a multiply or divide starts
      if (cmd.mul_init || cmd.div_init) begin
        sv_r <= 1'b0; sa_r <= '0; sd_r <= '0;
        jt_r <= 1'b0; jtg_r <= '0; jr_r <= 1'b0;
        rf_r <= 1'b0; df_r <= 1'b0;
      end
      // Iterative multiply: shift-add, one multiplier bit per step
      if (cmd.mul_init) begin
        a_r <= ac_r; b_r <= m; p_r <= '0;
      end else if (cmd.div_init) begin
        q_r    <= ac_abs; b_r <= m_abs; rem_r <= '0;
        qneg_r <= ac_r[WORD_BITS-1] ^ m[WORD_BITS-1];
        rneg_r <= ac_r[WORD_BITS-1];
      end else if (cmd.step) begin
        if (mul_r) begin
          p_r <= b_r[0] ? p_r + a_r : p_r;
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
        // Restoring divide, one quotient bit per step; divisor stays put
        if (div_r) begin
          if (!trial[WORD_BITS]) begin
            rem_r <= trial[WORD_BITS-1:0];
            q_r   <= {q_r[WORD_BITS-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[WORD_BITS-2:0], q_r[WORD_BITS-1]};
            q_r   <= {q_r[WORD_BITS-2:0], 1'b0};
          end
        end
      end else if (cmd.mul_done) begin
        ac_r <= p_r;
      end else if (cmd.div_done) begin
        mq_r <= qneg_r ? -q_r : q_r;
        ac_r <= rneg_r ? -rem_r : rem_r;
      end
      // Track which unit runs so step knows the operation
      if (cmd.mul_init) begin mul_r <= 1'b1; div_r <= 1'b0; end
      if (cmd.div_init) begin div_r <= 1'b1; mul_r <= 1'b0; end
    end
  end

  // Multiply steps also shift b_r; keep divisor stable in divide
  assign r_store_valid     = sv_r;
  assign r_store_addr      = sa_r;
  assign r_store_data      = sd_r;
  assign r_jump_taken      = jt_r;
  assign r_jump_target     = jtg_r;
  assign r_jump_right_half = jr_r;
  assign r_refetch         = rf_r;
  assign r_halted          = halt_r;
  assign r_divide_fault    = df_r;
  assign r_acc             = ac_r;

  unused_mul_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (mul_r || div_r)) else $error("step without operation");
endmodule

// ----- design/ias_ctrl.sv -----
// Controller of the IAS execute unit: handshakes and mul/div sequencing.
// Depends on ias_pkg.
`timescale 1ns / 1ps
module ias_ctrl #(
  parameter int WORD_BITS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ias_pkg::ias_sts_t sts,
  output ias_pkg::ias_cmd_t cmd
);
  localparam int CW = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_STEP, S_FIN, S_OUT} state_t;
  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic            div_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Decode commands from state and, in S_IDLE, from in_valid and sts; the operand
  // stays on the input pins only at acceptance, so the datapath registers it then.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.load = 1'b0;
      S_LOAD: begin
        cmd.load     = 1'b0;
      end
      S_STEP: cmd.step = 1'b1;
      S_FIN: begin
        cmd.mul_done = !div_r;
        cmd.div_done = div_r;
      end
      S_OUT: ;
      default: ;
    endcase
    if (state_r == S_IDLE && in_valid) begin
      cmd.load     = !(sts.is_mul || sts.is_div);
      cmd.mul_init = sts.is_mul;
      cmd.div_init = sts.is_div;
    end
  end

  // Hold state; advance through mul/div iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      div_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          if (sts.is_mul || sts.is_div) begin
            state_r <= S_STEP;
            div_r   <= sts.is_div;
            cnt_r   <= CW'(WORD_BITS - 1);
          end else state_r <= S_OUT;
        end
        S_LOAD: state_r <= S_IDLE;
        S_STEP: begin
          if (cnt_r == '0) state_r <= S_FIN;
          cnt_r <= cnt_r - 1'b1;
        end
        S_FIN: state_r <= S_OUT;
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_fin_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> $past(state_r) == S_STEP) else $error("bad finish");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// ----- design/ias_execute_unit.sv -----
// Channel       | Dir | Payload
// in            | in  | end_marker, opcode, address, operand
// out           | out | store/jump/refetch/halt/fault flags, acc_value
// Most opcodes go from S_IDLE straight to S_OUT; multiply and divide pass through
// S_STEP (one multiplier/quotient bit per cycle in the shared unit) and S_FIN first.
// One transaction at a time; the result is held until out is taken.
// Reset (rst_n, synchronous) clears AC, MQ and the halt flag.
// Top level of the IAS execute unit. Depends on ias_pkg, ias_ctrl, ias_datapath.
`timescale 1ns / 1ps
module ias_execute_unit #(
  parameter int WORD_BITS = 40,
  parameter int ADDR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_end_marker,
  input  logic [7:0]           in_opcode,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [WORD_BITS-1:0] in_operand,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_store_valid,
  output logic [ADDR_BITS-1:0] out_store_addr,
  output logic [WORD_BITS-1:0] out_store_data,
  output logic                 out_jump_taken,
  output logic [ADDR_BITS-1:0] out_jump_target,
  output logic                 out_jump_right_half,
  output logic                 out_refetch,
  output logic                 out_halted,
  output logic                 out_divide_fault,
  output logic [WORD_BITS-1:0] out_acc_value
);
  ias_pkg::ias_cmd_t cmd;
  ias_pkg::ias_sts_t sts;

  ias_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  ias_datapath #(.WORD_BITS(WORD_BITS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_end_marker, .in_opcode, .in_address,
    .in_operand,
    .r_store_valid(out_store_valid), .r_store_addr(out_store_addr),
    .r_store_data(out_store_data), .r_jump_taken(out_jump_taken),
    .r_jump_target(out_jump_target), .r_jump_right_half(out_jump_right_half),
    .r_refetch(out_refetch), .r_halted(out_halted),
    .r_divide_fault(out_divide_fault), .r_acc(out_acc_value)
  );
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for ias_execute_unit: directed and random instruction streams.
// Depends on ias_pkg, ias_if and the execute unit RTL.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic        end_marker;
    logic [7:0]  opcode;
    logic [11:0] address;
    logic [39:0] operand;
  } instr_t;

  typedef struct packed {
    logic        store_valid;
    logic [11:0] store_addr;
    logic [39:0] store_data;
    logic        jump_taken;
    logic [11:0] jump_target;
    logic        jump_right_half;
    logic        refetch;
    logic        halted;
    logic        divide_fault;
    logic [39:0] acc_value;
  } result_t;

  typedef struct {
    instr_t ins;
    bit     drain_first;
  } pending_t;

  localparam logic [39:0] SIGN_BIT = 40'h80_0000_0000;
  localparam logic [39:0] MAX_POS  = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] ALL_ONES = 40'hFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ias_if #(.payload_t(instr_t))  in_ch ();
  ias_if #(.payload_t(result_t)) out_ch ();

  ias_execute_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_end_marker(in_ch.data.end_marker), .in_opcode(in_ch.data.opcode),
    .in_address(in_ch.data.address), .in_operand(in_ch.data.operand),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_store_valid(out_ch.data.store_valid), .out_store_addr(out_ch.data.store_addr),
    .out_store_data(out_ch.data.store_data), .out_jump_taken(out_ch.data.jump_taken),
    .out_jump_target(out_ch.data.jump_target),
    .out_jump_right_half(out_ch.data.jump_right_half),
    .out_refetch(out_ch.data.refetch), .out_halted(out_ch.data.halted),
    .out_divide_fault(out_ch.data.divide_fault), .out_acc_value(out_ch.data.acc_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow machine state
  logic [39:0] shadow_ac = '0;
  logic [39:0] shadow_mq = '0;
  logic        shadow_halt = 1'b0;

  pending_t program_q[$];
  result_t  expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_long = 0;
  int n_ignored = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;

  function automatic logic [39:0] neg40(logic [39:0] x);
    return 40'd0 - x;
  endfunction

  function automatic logic [39:0] abs40(logic [39:0] x);
    return x[39] ? neg40(x) : x;
  endfunction

  // Compute the result of one instruction and advance the shadow state
  function automatic result_t execute_instr(instr_t ins);
    result_t r;
    logic [39:0] ac, m, mag_a, mag_b, quo, rem;
    r = '0;
    ac = shadow_ac;
    m = ins.operand;
    if (shadow_halt) begin
      n_ignored++;
    end else if (ins.end_marker) begin
      shadow_halt = 1'b1;
    end else begin
      case (ins.opcode)
        ias_pkg::OP_LOAD:      ac = m;
        ias_pkg::OP_LOAD_NEG:  ac = neg40(m);
        ias_pkg::OP_LOAD_ABS:  ac = abs40(m);
        ias_pkg::OP_LOAD_NABS: ac = neg40(abs40(m));
        ias_pkg::OP_ADD:       ac = ac + m;
        ias_pkg::OP_SUB:       ac = ac - m;
        ias_pkg::OP_ADD_ABS:   ac = ac + abs40(m);
        ias_pkg::OP_SUB_ABS:   ac = ac - abs40(m);
        ias_pkg::OP_LOAD_MQ:   shadow_mq = m;
        ias_pkg::OP_MQ_TO_AC:  ac = shadow_mq;
        ias_pkg::OP_MUL: begin
          ac = ac * m;
          n_long++;
        end
        ias_pkg::OP_DIV: begin
          n_long++;
          if (m == '0) begin
            r.divide_fault = 1'b1;
          end else begin
            mag_a = abs40(ac);
            mag_b = abs40(m);
            quo = mag_a / mag_b;
            rem = mag_a % mag_b;
            if (ac[39] != m[39]) quo = neg40(quo);
            if (ac[39]) rem = neg40(rem);
            shadow_mq = quo;
            ac = rem;
          end
        end
        ias_pkg::OP_JMP_L, ias_pkg::OP_JMP_R, ias_pkg::OP_JPOS_L,
        ias_pkg::OP_JPOS_R: begin
          if (ins.opcode == ias_pkg::OP_JMP_L || ins.opcode == ias_pkg::OP_JMP_R
              || !ac[39]) begin
            r.jump_taken = 1'b1;
            r.jump_target = ins.address;
            r.jump_right_half = (ins.opcode == ias_pkg::OP_JMP_R
                                 || ins.opcode == ias_pkg::OP_JPOS_R);
          end
        end
        ias_pkg::OP_STOR_L: begin
          r.store_valid = 1'b1;
          r.store_addr = ins.address;
          r.store_data = m;
          r.store_data[31:20] = ac[11:0];
          r.refetch = 1'b1;
        end
        ias_pkg::OP_STOR_R: begin
          r.store_valid = 1'b1;
          r.store_addr = ins.address;
          r.store_data = {m[39:12], ac[11:0]};
          r.refetch = 1'b1;
        end
        ias_pkg::OP_LSH: ac = {ac[38:0], 1'b0};
        ias_pkg::OP_RSH: ac = {ac[39], ac[39:1]};
        ias_pkg::OP_STOR: begin
          r.store_valid = 1'b1;
          r.store_addr = ins.address;
          r.store_data = ac;
        end
        default: ;
      endcase
      shadow_ac = ac;
    end
    r.halted = shadow_halt;
    r.acc_value = shadow_ac;
    return r;
  endfunction

  function automatic logic [39:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 40'd1;
      2: return ALL_ONES;
      3: return MAX_POS;
      4: return SIGN_BIT;
      5: return 40'($urandom_range(0, 300));
      6: return neg40(40'($urandom_range(1, 300)));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [7:0] ops[21] = '{
      ias_pkg::OP_LOAD, ias_pkg::OP_LOAD_NEG, ias_pkg::OP_LOAD_ABS,
      ias_pkg::OP_LOAD_NABS, ias_pkg::OP_ADD, ias_pkg::OP_SUB,
      ias_pkg::OP_ADD_ABS, ias_pkg::OP_SUB_ABS, ias_pkg::OP_LOAD_MQ,
      ias_pkg::OP_MQ_TO_AC, ias_pkg::OP_MUL, ias_pkg::OP_DIV,
      ias_pkg::OP_JMP_L, ias_pkg::OP_JMP_R, ias_pkg::OP_JPOS_L,
      ias_pkg::OP_JPOS_R, ias_pkg::OP_STOR_L, ias_pkg::OP_STOR_R,
      ias_pkg::OP_LSH, ias_pkg::OP_RSH, ias_pkg::OP_STOR};
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return ops[$urandom_range(0, 20)];
  endfunction

  task automatic push_instr(logic [7:0] op, logic [39:0] word, bit drain = 1'b0);
    pending_t p;
    p.ins.end_marker = 1'b0;
    p.ins.opcode = op;
    p.ins.address = 12'($urandom);
    p.ins.operand = word;
    p.drain_first = drain;
    program_q.push_back(p);
  endtask

  // Fill the program: directed corners, random body, halt marker, four trailing instructions
  initial begin
    pending_t p;
    push_instr(ias_pkg::OP_LOAD, SIGN_BIT);
    push_instr(ias_pkg::OP_LOAD_NEG, SIGN_BIT);
    push_instr(ias_pkg::OP_LOAD_ABS, SIGN_BIT);
    push_instr(ias_pkg::OP_LOAD_NABS, MAX_POS);
    push_instr(ias_pkg::OP_ADD, MAX_POS);
    push_instr(ias_pkg::OP_SUB, ALL_ONES);
    push_instr(ias_pkg::OP_ADD_ABS, ALL_ONES);
    push_instr(ias_pkg::OP_SUB_ABS, SIGN_BIT);
    push_instr(ias_pkg::OP_LOAD_MQ, 40'd12345);
    push_instr(ias_pkg::OP_MQ_TO_AC, '0);
    push_instr(ias_pkg::OP_MUL, MAX_POS);
    push_instr(ias_pkg::OP_LOAD, SIGN_BIT);
    push_instr(ias_pkg::OP_DIV, ALL_ONES);
    push_instr(ias_pkg::OP_DIV, '0);
    push_instr(ias_pkg::OP_LOAD, neg40(40'd100));
    push_instr(ias_pkg::OP_DIV, 40'd7);
    push_instr(ias_pkg::OP_JMP_L, '0);
    push_instr(ias_pkg::OP_JMP_R, '0);
    push_instr(ias_pkg::OP_JPOS_L, '0);
    push_instr(ias_pkg::OP_LOAD, '0);
    push_instr(ias_pkg::OP_JPOS_R, '0);
    push_instr(ias_pkg::OP_LOAD, ALL_ONES);
    push_instr(ias_pkg::OP_STOR_L, '0);
    push_instr(ias_pkg::OP_STOR_R, MAX_POS);
    push_instr(ias_pkg::OP_LSH, '0);
    push_instr(ias_pkg::OP_RSH, '0);
    push_instr(ias_pkg::OP_STOR, '0);
    push_instr(8'hFF, ALL_ONES);
    for (int i = 0; i < 1020; i++)
      push_instr(pick_opcode(), pick_word(), i == 500);
    p.ins = '{end_marker: 1'b1, opcode: 8'($urandom), address: 12'($urandom),
              operand: ALL_ONES};
    p.drain_first = 1'b0;
    program_q.push_back(p);
    for (int i = 0; i < 4; i++) push_instr(pick_opcode(), pick_word());
  end

  // Sender: offer items, hold each until accepted, random gaps in between except in bursts
  int send_gap = 0;
  bit send_burst = 1'b0;
  always @(posedge clk) begin
    bit nxt_valid;
    pending_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(execute_instr(in_ch.data));
        n_sent++;
        nxt_valid = 1'b0;
        if (n_sent % 150 == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 17);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (program_q.size() > 0 &&
                     !(program_q[0].drain_first && expected_q.size() > 0)) begin
          p = program_q.pop_front();
          in_ch.data <= p.ins;
          nxt_valid = 1'b1;
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  int recv_stall = 0;
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_ch.data);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_ch.data) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, out_ch.data);
            errors++;
          end
        end
        recv_stall = (n_results / 150) % 2 ? 0 : $urandom_range(0, 17);
        if (n_results == 700 && !hold_done) begin
          recv_stall = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("** ias_execute_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (program_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
    repeat (60) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, expected_q.size());
      errors++;
    end
    $display("Ran %0d instructions, %0d results checked, %0d multiply/divide.",
             n_sent, n_results, n_long);
    $display("Halt marker reached; %0d trailing instructions ignored. Errors: %0d",
             n_ignored, errors);
    if (errors == 0)
      $display("** ias_execute_unit: PASSED **");
    else
      $display("** ias_execute_unit: FAILED **");
    $finish;
  end

endmodule
